// ===== hw/rtl/shcc_pkg.sv =====
// Shared types and constants of the save image header CRC checker.
// Used by every other file of the block except shcc_fifo; depends on nothing.
`default_nettype none

package shcc_pkg;

   // Defaults of the top level parameters.
   localparam int MAX_PAYLOAD_BYTES_DEF = 16384;
   localparam int HEADER_BYTES_DEF      = 32;

   // Depths of the queue between the two halves and of the result queue.
   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_SIZE = 1'd1;

   localparam logic [31:0] CSR_VERSION_RST      = 32'd1;
   localparam logic [14:0] CSR_PAYLOAD_SIZE_RST = 15'd16352;

   // The fixed header fields all end before this byte position.
   localparam int HDR_FIELD_END = 24;

   // Failure reason codes, in the order the checks are applied.
   localparam logic [2:0] REASON_OK      = 3'd0;
   localparam logic [2:0] REASON_MAGIC   = 3'd1;
   localparam logic [2:0] REASON_VERSION = 3'd2;
   localparam logic [2:0] REASON_SIZE    = 3'd3;
   localparam logic [2:0] REASON_CRC     = 3'd4;

   // One classified byte handed from the front to the back.
   typedef struct packed {
      logic [7:0] data;
      logic       start;
      logic [4:0] hdr_pos;
      logic       in_header;
      logic       is_payload;
      logic       last;
   } entry_type;

   // One verdict.
   typedef struct packed {
      logic        image_valid;
      logic [2:0]  fail_reason;
      logic [31:0] boot_count;
      logic [31:0] stored_crc;
      logic [31:0] computed_crc;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/save_image_header_crc_checker_unit.sv =====
// Top level of the save image header CRC checker: configuration registers,
// front and back halves and their queues. Depends on shcc_pkg and all shcc_ modules.
`default_nettype none

// Channel    Ports                                   Direction  Beat accepted when
// request    req_push, req_full, req_data_byte,      in         req_push && !req_full
//            req_start_of_image
// response   rsp_pop, rsp_empty, rsp_image_valid,    out        rsp_pop && !rsp_empty
//            rsp_fail_reason, rsp_boot_count,
//            rsp_stored_crc, rsp_computed_crc
// config     csr_we, csr_index, csr_wdata            in         csr_we
//
// The block takes one byte per cycle while req_full is low. The figure is set by the
// bytewise CRC update in the back half, which finishes one byte each cycle.
// A verdict appears on the response ports once the back half has read the final
// byte from the middle queue and written the verdict into the result queue; a full
// result queue holds that final byte in the middle queue until room frees up.
// Reset is synchronous and active high; it restores the register defaults and
// leaves the block waiting for a start byte. No clearing pass follows reset.
// When the result queue is full, the back half holds only a final byte, and the
// front keeps taking bytes until the small middle queue also fills.

module save_image_header_crc_checker_unit
   import shcc_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
   parameter int HEADER_BYTES      = HEADER_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_start_of_image,
   input  wire logic                 rsp_pop,
   output logic                      rsp_empty,
   output logic                      rsp_image_valid,
   output logic [2:0]                rsp_fail_reason,
   output logic [31:0]               rsp_boot_count,
   output logic [31:0]               rsp_stored_crc,
   output logic [31:0]               rsp_computed_crc,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);

   // Configuration registers.
   logic [31:0]      version_ff;
   logic [14:0]      size_ff;
   logic [LEN_W-1:0] payload_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= CSR_VERSION_RST;
         size_ff    <= CSR_PAYLOAD_SIZE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VERSION:      version_ff <= csr_wdata;
            CSR_PAYLOAD_SIZE: size_ff    <= csr_wdata[14:0];
            default:          version_ff <= version_ff;
         endcase
      end
   end

   // The payload length is the size register held within one and the maximum.
   // Both the image length and the header size check use this value.
   always_comb begin
      if (size_ff == '0) begin
         payload_len = LEN_W'(1);
      end else if (32'(size_ff) > 32'(MAX_PAYLOAD_BYTES)) begin
         payload_len = LEN_W'(MAX_PAYLOAD_BYTES);
      end else begin
         payload_len = LEN_W'(size_ff);
      end
   end

   // Front half and the queue to the back half.
   logic       mid_push, mid_full, mid_pop, mid_empty;
   entry_type  front_entry, back_entry;

   assign req_full = mid_full;

   shcc_front #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .HEADER_BYTES      (HEADER_BYTES),
      .LEN_W             (LEN_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .data_byte      (req_data_byte),
      .start_of_image (req_start_of_image),
      .payload_len    (payload_len),
      .mid_full       (mid_full),
      .mid_push       (mid_push),
      .mid_entry      (front_entry)
   );

   shcc_fifo #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (front_entry),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (back_entry),
      .empty (mid_empty)
   );

   // Back half and the result queue.
   logic       out_push, out_full;
   result_type back_result, rsp_result;

   shcc_back #(
      .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
      .LEN_W             (LEN_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .mid_empty        (mid_empty),
      .mid_entry        (back_entry),
      .mid_pop          (mid_pop),
      .expected_version (version_ff),
      .payload_len      (payload_len),
      .out_full         (out_full),
      .out_push         (out_push),
      .out_data         (back_result)
   );

   shcc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_result),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_result),
      .empty (rsp_empty)
   );

   assign rsp_image_valid  = rsp_result.image_valid;
   assign rsp_fail_reason  = rsp_result.fail_reason;
   assign rsp_boot_count   = rsp_result.boot_count;
   assign rsp_stored_crc   = rsp_result.stored_crc;
   assign rsp_computed_crc = rsp_result.computed_crc;

endmodule

`default_nettype wire

// ===== hw/rtl/shcc_fifo.sv =====
// Small first-in first-out queue with queue-style push/full, pop/empty ports.
// Generic; depends on no package.
`default_nettype none

module shcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/shcc_front.sv =====
// Front half: tracks the byte position of the image and classifies each byte.
// Depends on shcc_pkg.
`default_nettype none

module shcc_front
   import shcc_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
   parameter int HEADER_BYTES      = HEADER_BYTES_DEF,
   parameter int LEN_W             = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [7:0]       data_byte,
   input  wire logic             start_of_image,
   input  wire logic [LEN_W-1:0] payload_len,
   input  wire logic             mid_full,
   output logic                  mid_push,
   output entry_type             mid_entry
);

   localparam int POS_W = $clog2(HEADER_BYTES + MAX_PAYLOAD_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_cur, pos_next, end_pos;
   logic             done_ff, done_in;
   logic             take, active, last;

   assign take     = push && !mid_full;
   assign active   = start_of_image || !done_ff;
   assign pos_cur  = start_of_image ? '0 : pos_ff;
   assign pos_next = pos_cur + 1'b1;
   assign end_pos  = POS_W'(HEADER_BYTES) + POS_W'(payload_len);
   assign last     = (pos_next >= end_pos);
   assign mid_push = take && active;

   always_comb begin
      mid_entry.data       = data_byte;
      mid_entry.start      = start_of_image;
      mid_entry.hdr_pos    = pos_cur[4:0];
      mid_entry.in_header  = (pos_cur < POS_W'(HDR_FIELD_END));
      mid_entry.is_payload = (pos_cur >= POS_W'(HEADER_BYTES));
      mid_entry.last       = last;
   end

   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (take && active) begin
         pos_in  = pos_next;
         done_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b1;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/shcc_back.sv =====
// Back half: captures the header words, runs the payload CRC and forms the verdict.
// Depends on shcc_pkg.
`default_nettype none

module shcc_back
   import shcc_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
   parameter int LEN_W             = $clog2(MAX_PAYLOAD_BYTES + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             mid_empty,
   input  wire entry_type        mid_entry,
   output logic                  mid_pop,
   input  wire logic [31:0]      expected_version,
   input  wire logic [LEN_W-1:0] payload_len,
   input  wire logic             out_full,
   output logic                  out_push,
   output result_type            out_data
);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] put_lane(input logic [31:0] word, input logic [1:0] lane,
                                            input logic [7:0] b);
      logic [31:0] w;
      w = word;
      case (lane)
         2'd0:    w[7:0]   = b;
         2'd1:    w[15:8]  = b;
         2'd2:    w[23:16] = b;
         2'd3:    w[31:24] = b;
         default: w = word;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] m;
      case (idx)
         3'd0:    m = "W";
         3'd1:    m = "C";
         3'd2:    m = "1";
         3'd3:    m = "S";
         3'd4:    m = "A";
         3'd5:    m = "V";
         3'd6:    m = "E";
         default: m = 8'd0;
      endcase
      return m;
   endfunction

   logic        magic_ok_ff, magic_ok_in, magic_base;
   logic [31:0] version_ff, version_in, version_base;
   logic [31:0] size_ff, size_in, size_base;
   logic [31:0] counter_ff, counter_in, counter_base;
   logic [31:0] hcrc_ff, hcrc_in, hcrc_base;
   logic [31:0] crc_ff, crc_in, crc_base;
   logic [31:0] computed;
   logic [2:0]  reason;
   logic        go;

   assign go      = !mid_empty && (!mid_entry.last || !out_full);
   assign mid_pop = go;

   always_comb begin
      // A start byte begins from a cleared image.
      magic_base   = mid_entry.start ? 1'b1 : magic_ok_ff;
      version_base = mid_entry.start ? '0 : version_ff;
      size_base    = mid_entry.start ? '0 : size_ff;
      counter_base = mid_entry.start ? '0 : counter_ff;
      hcrc_base    = mid_entry.start ? '0 : hcrc_ff;
      crc_base     = mid_entry.start ? '1 : crc_ff;

      magic_ok_in = magic_base;
      version_in  = version_base;
      size_in     = size_base;
      counter_in  = counter_base;
      hcrc_in     = hcrc_base;
      crc_in      = crc_base;

      if (mid_entry.in_header) begin
         case (mid_entry.hdr_pos[4:2])
            3'd0, 3'd1: begin
               if (mid_entry.data != magic_byte(mid_entry.hdr_pos[2:0])) begin
                  magic_ok_in = 1'b0;
               end
            end
            3'd2:    version_in = put_lane(version_base, mid_entry.hdr_pos[1:0], mid_entry.data);
            3'd3:    size_in    = put_lane(size_base, mid_entry.hdr_pos[1:0], mid_entry.data);
            3'd4:    counter_in = put_lane(counter_base, mid_entry.hdr_pos[1:0], mid_entry.data);
            3'd5:    hcrc_in    = put_lane(hcrc_base, mid_entry.hdr_pos[1:0], mid_entry.data);
            default: magic_ok_in = magic_base;
         endcase
      end
      if (mid_entry.is_payload) begin
         crc_in = crc_byte(crc_base, mid_entry.data);
      end

      computed = ~crc_in;
      if (!magic_ok_in) begin
         reason = REASON_MAGIC;
      end else if (version_in != expected_version) begin
         reason = REASON_VERSION;
      end else if (size_in != 32'(payload_len)) begin
         reason = REASON_SIZE;
      end else if (computed != hcrc_in) begin
         reason = REASON_CRC;
      end else begin
         reason = REASON_OK;
      end

      out_data.image_valid  = (reason == REASON_OK);
      out_data.fail_reason  = reason;
      out_data.boot_count   = counter_in;
      out_data.stored_crc   = hcrc_in;
      out_data.computed_crc = computed;
   end

   assign out_push = go && mid_entry.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ok_ff <= 1'b1;
         version_ff  <= '0;
         size_ff     <= '0;
         counter_ff  <= '0;
         hcrc_ff     <= '0;
         crc_ff      <= '1;
      end else if (go) begin
         magic_ok_ff <= magic_ok_in;
         version_ff  <= version_in;
         size_ff     <= size_in;
         counter_ff  <= counter_in;
         hcrc_ff     <= hcrc_in;
         crc_ff      <= crc_in;
      end
   end

   // A verdict is never offered to a full result queue.
   assert property (@(posedge clock) disable iff (reset) out_push |-> !out_full)
      else $error("verdict pushed into full result queue");

   // A passing verdict carries matching CRC words.
   assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.fail_reason == REASON_OK) |->
         (out_data.computed_crc == out_data.stored_crc && out_data.image_valid))
      else $error("ok verdict with mismatched CRC");

   // The start byte of an image is a magic byte, so the header words restart at zero.
   assert property (@(posedge clock) disable iff (reset)
      (go && mid_entry.start) |=>
         (version_ff == '0 && counter_ff == '0 && hcrc_ff == '0 && crc_ff == '1))
      else $error("header state not cleared by start byte");

endmodule

`default_nettype wire

// ===== bench/save_image_header_crc_checker_unit_tb.sv =====
// Self-checking bench for save_image_header_crc_checker_unit: byte stream in,
// verdict queue out, verdicts predicted by an in-bench image tracker.
// Depends on shcc_pkg and the block's RTL only.

module save_image_header_crc_checker_unit_tb;
   import shcc_pkg::*;

   // The run normally ends well below this; it only catches a hung block.
   localparam int CYCLE_LIMIT   = 3_000_000;
   // Cycles allowed after the last verdict for bytes still inside the block.
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_BYTES  = 1070;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   // Position past the last signature byte: means the signature is left intact.
   localparam int SIG_INTACT = 8;

   // Eight-byte signature that opens every header, trailing zero included.
   localparam logic [7:0] SIGNATURE [8] = '{8'h57, 8'h43, 8'h31, 8'h53,
                                            8'h41, 8'h56, 8'h45, 8'h00};

   // One directed image: optional register setup, stray bytes ahead of it,
   // the header fields, and the ways the byte stream may be broken.
   typedef struct packed {
      logic        set_cfg;
      logic [31:0] cfg_version;
      logic [31:0] cfg_size;
      logic [3:0]  strays;
      logic [3:0]  bad_magic;
      logic [31:0] hdr_version;
      logic [31:0] hdr_size;
      logic [31:0] hdr_count;
      logic        crc_good;
      logic [15:0] payload;
      logic [7:0]  cut;
      logic [7:0]  resize_at;
      logic [31:0] resize_to;
      logic        typed;
      logic [2:0]  reason;
   } image_plan_type;

   localparam int PLAN_ROWS = 12;
   localparam image_plan_type PLAN [PLAN_ROWS] = '{
      // Default version after reset, strays first; the default length keeps the
      // image open through its header until the size is lowered.
      '{1'b0, 32'd0, 32'd0, 4'd3, 4'd8, 32'd1, 32'd4, 32'd0,
        1'b1, 16'd4, 8'd0, 8'd32, 32'd4, 1'b1, REASON_OK},
      // Smallest payload, version zero, boot counter all ones.
      '{1'b1, 32'd0, 32'd1, 4'd0, 4'd8, 32'd0, 32'd1, 32'hFFFF_FFFF,
        1'b1, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_OK},
      '{1'b0, 32'd0, 32'd0, 4'd0, 4'd0, 32'd0, 32'd1, 32'd1,
        1'b1, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_MAGIC},
      // Broken terminator with every later check failing too: magic wins.
      '{1'b0, 32'd0, 32'd0, 4'd2, 4'd7, 32'd5, 32'd9, 32'd2,
        1'b0, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_MAGIC},
      '{1'b0, 32'd0, 32'd0, 4'd0, 4'd8, 32'd1, 32'd2, 32'd3,
        1'b0, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_VERSION},
      // Size word right in its low bits but not in the upper half.
      '{1'b0, 32'd0, 32'd0, 4'd0, 4'd8, 32'd0, 32'h0001_0001, 32'd4,
        1'b1, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_SIZE},
      '{1'b0, 32'd0, 32'd0, 4'd0, 4'd8, 32'd0, 32'd1, 32'd5,
        1'b0, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_CRC},
      // Size register zero is taken as one byte.
      '{1'b1, 32'hFFFF_FFFF, 32'd0, 4'd0, 4'd8, 32'hFFFF_FFFF, 32'd1, 32'd6,
        1'b1, 16'd1, 8'd0, 8'd0, 32'd0, 1'b1, REASON_OK},
      // A new start inside the header of an unfinished image.
      '{1'b1, 32'h5A5A_0F0F, 32'd5, 4'd0, 4'd8, 32'h5A5A_0F0F, 32'd5, 32'd7,
        1'b1, 16'd5, 8'd20, 8'd0, 32'd0, 1'b0, REASON_OK},
      // A new start inside the payload of an unfinished image.
      '{1'b0, 32'd0, 32'd0, 4'd2, 4'd8, 32'h5A5A_0F0F, 32'd5, 32'd8,
        1'b1, 16'd5, 8'd36, 8'd0, 32'd0, 1'b0, REASON_OK},
      // Size shrunk under an open image: it ends at once, leftovers ignored.
      '{1'b1, 32'h5A5A_0F0F, 32'd8, 4'd0, 4'd8, 32'h5A5A_0F0F, 32'd8, 32'd9,
        1'b1, 16'd8, 8'd0, 8'd36, 32'd2, 1'b0, REASON_OK},
      // All-ones size write clamps to the largest payload, so the image stays
      // open through its first payload bytes until the size is lowered.
      '{1'b1, 32'hC3C3_3C3C, 32'hFFFF_FFFF, 4'd1, 4'd8, 32'hC3C3_3C3C, 32'd3,
        32'd10, 1'b1, 16'd3, 8'd0, 8'd34, 32'd3, 1'b1, REASON_OK}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [7:0]           req_data_byte;
   logic                 req_start_of_image;
   logic                 rsp_pop;
   logic                 rsp_empty;
   logic                 rsp_image_valid;
   logic [2:0]           rsp_fail_reason;
   logic [31:0]          rsp_boot_count;
   logic [31:0]          rsp_stored_crc;
   logic [31:0]          rsp_computed_crc;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   // Register copies as the block should hold them.
   logic [31:0] cfg_version;
   logic [14:0] cfg_size;

   // Image tracker state, mirroring what the block keeps per image.
   int unsigned trk_pos;
   logic [31:0] trk_crc;
   logic        trk_magic_ok;
   logic [31:0] trk_version;
   logic [31:0] trk_size;
   logic [31:0] trk_count;
   logic [31:0] trk_stored_crc;
   logic        trk_idle;

   // Verdicts predicted but not yet popped, oldest first.
   result_type verdicts_due [$];

   // Directed rows may pin the reason code of their verdict.
   logic       typed_on;
   logic [2:0] typed_reason;

   // Idling controls: calm switches all idling off for the final stretch.
   logic calm;
   logic tx_choppy;
   logic rx_choppy;
   int   stall_left;

   int cycles;
   int mismatches;
   int verdicts_checked;
   int images_sent;
   int image_bytes;

   save_image_header_crc_checker_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_start_of_image (req_start_of_image),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_image_valid    (rsp_image_valid),
      .rsp_fail_reason    (rsp_fail_reason),
      .rsp_boot_count     (rsp_boot_count),
      .rsp_stored_crc     (rsp_stored_crc),
      .rsp_computed_crc   (rsp_computed_crc),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reflected CRC-32, one byte, LSB first.
   function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
      c = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Payload length in effect: the register value held to 1..MAX.
   function automatic int unsigned payload_len();
      int unsigned n;
      n = 32'(cfg_size);
      if (n < 1) n = 1;
      if (n > MAX_PAYLOAD_BYTES_DEF) n = MAX_PAYLOAD_BYTES_DEF;
      return n;
   endfunction

   task automatic note_mismatch(input string what);
      $display("[%0d] MISMATCH: %s", cycles, what);
      mismatches++;
   endtask

   // Advance the tracker by one accepted byte and queue the verdict it closes, if any.
   function automatic void track_byte(input logic [7:0] b, input logic first);
      int unsigned at;
      int unsigned len;
      logic [31:0] computed;
      logic [2:0]  why;
      result_type  v;
      if (first) begin
         trk_pos        = 0;
         trk_crc        = '1;
         trk_magic_ok   = 1'b1;
         trk_version    = '0;
         trk_size       = '0;
         trk_count      = '0;
         trk_stored_crc = '0;
         trk_idle       = 1'b0;
      end
      // Stray bytes between images are dropped.
      if (trk_idle) return;
      at  = trk_pos;
      len = payload_len();
      if (at < 8) begin
         if (b != SIGNATURE[at]) trk_magic_ok = 1'b0;
      end else if (at < 12) begin
         trk_version[8*(at-8) +: 8] = b;
      end else if (at < 16) begin
         trk_size[8*(at-12) +: 8] = b;
      end else if (at < 20) begin
         trk_count[8*(at-16) +: 8] = b;
      end else if (at < HDR_FIELD_END) begin
         trk_stored_crc[8*(at-20) +: 8] = b;
      end
      if (at >= HEADER_BYTES_DEF) trk_crc = crc_step(trk_crc, b);
      trk_pos = at + 1;
      // The image closes on the first byte at or past its last position, which
      // also covers a size register lowered while the image was open.
      if (at + 1 < HEADER_BYTES_DEF + len) return;
      trk_idle = 1'b1;
      computed = ~trk_crc;
      if (!trk_magic_ok) why = REASON_MAGIC;
      else if (trk_version != cfg_version) why = REASON_VERSION;
      else if (trk_size != len) why = REASON_SIZE;
      else if (computed != trk_stored_crc) why = REASON_CRC;
      else why = REASON_OK;
      if (typed_on) why = typed_reason;
      v.image_valid  = (why == REASON_OK);
      v.fail_reason  = why;
      v.boot_count   = trk_count;
      v.stored_crc   = trk_stored_crc;
      v.computed_crc = computed;
      verdicts_due.push_back(v);
   endfunction

   task automatic check_verdict();
      result_type want;
      if (verdicts_due.size() == 0) begin
         note_mismatch("verdict popped with none expected");
         return;
      end
      want = verdicts_due.pop_front();
      verdicts_checked++;
      if (rsp_image_valid !== want.image_valid)
         note_mismatch($sformatf("image_valid %b, expected %b",
                                 rsp_image_valid, want.image_valid));
      if (rsp_fail_reason !== want.fail_reason)
         note_mismatch($sformatf("fail_reason %0d, expected %0d",
                                 rsp_fail_reason, want.fail_reason));
      if (rsp_boot_count !== want.boot_count)
         note_mismatch($sformatf("boot_count %h, expected %h",
                                 rsp_boot_count, want.boot_count));
      if (rsp_stored_crc !== want.stored_crc)
         note_mismatch($sformatf("stored_crc %h, expected %h",
                                 rsp_stored_crc, want.stored_crc));
      if (rsp_computed_crc !== want.computed_crc)
         note_mismatch($sformatf("computed_crc %h, expected %h",
                                 rsp_computed_crc, want.computed_crc));
   endtask

   // Everything is sampled at the rising edge, where inputs driven at the
   // falling edge are stable and the block's outputs still hold their old values.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding",
                  cycles, verdicts_due.size());
         $display("save_image_header_crc_checker_unit_tb: done, errors");
         $finish;
      end
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_VERSION) cfg_version = csr_wdata;
            else if (csr_index == CSR_PAYLOAD_SIZE) cfg_size = csr_wdata[14:0];
         end
         if (req_push && !req_full) track_byte(req_data_byte, req_start_of_image);
         if (rsp_pop && !rsp_empty) check_verdict();
      end
   end

   // Result side: pop stalls come in bursts, and the mood flips now and then so
   // that long stall-free stretches occur as well.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_pop <= 1'b0;
      end else if (!calm && rx_choppy && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) rx_choppy = ($urandom_range(0, 2) != 0);
   end

   // One byte beat, preceded now and then by a gap with push low.
   // Returns at the rising edge that takes the beat; push stays high until
   // the next falling edge so back-to-back beats need no gap.
   task automatic push_byte(input logic [7:0] b, input logic first);
      int gap;
      if (!calm && tx_choppy && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 16);
         repeat (gap) begin
            @(negedge clock);
            req_push <= 1'b0;
         end
      end
      @(negedge clock);
      req_push           <= 1'b1;
      req_data_byte      <= b;
      req_start_of_image <= first;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_strays(input int n);
      for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
   endtask

   // Stop pushing, wait for every predicted verdict, then give bytes that
   // close no image time to leave the block.
   task automatic drain_results();
      @(negedge clock);
      req_push <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      drain_results();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Builds and sends one image. A nonzero cut_n first sends that many bytes of
   // an image that the real one then abandons; a nonzero resize_at rewrites the
   // size register in front of that byte, with the image left open meanwhile.
   task automatic run_image(input logic [31:0] hver, input logic [31:0] hsize,
                            input logic [31:0] hcnt, input int bad_at,
                            input bit crc_good, input int pay_n, input int cut_n,
                            input int resize_at, input logic [31:0] resize_to);
      logic [7:0]  img [$];
      logic [7:0]  pay [$];
      logic [31:0] words [4];
      logic [31:0] c;
      logic [7:0]  b;
      c = '1;
      for (int i = 0; i < pay_n; i++) begin
         b = 8'($urandom);
         pay.push_back(b);
         c = crc_step(c, b);
      end
      words[0] = hver;
      words[1] = hsize;
      words[2] = hcnt;
      words[3] = ~c;
      if (!crc_good) words[3] = words[3] ^ ($urandom | (32'd1 << $urandom_range(0, 31)));
      for (int i = 0; i < 8; i++) begin
         b = SIGNATURE[i];
         if (i == bad_at) b = b ^ 8'($urandom_range(1, 255));
         img.push_back(b);
      end
      for (int w = 0; w < 4; w++) begin
         for (int k = 0; k < 4; k++) img.push_back(words[w][8*k +: 8]);
      end
      for (int i = HDR_FIELD_END; i < HEADER_BYTES_DEF; i++) img.push_back(8'($urandom));
      foreach (pay[i]) img.push_back(pay[i]);

      for (int i = 0; i < cut_n; i++)
         push_byte((i < 8) ? SIGNATURE[i] : 8'($urandom), i == 0);
      for (int i = 0; i < img.size(); i++) begin
         if (resize_at != 0 && i == resize_at) write_reg(CSR_PAYLOAD_SIZE, resize_to);
         push_byte(img[i], i == 0);
      end
      image_bytes += cut_n + img.size();
      images_sent++;
   endtask

   // Mostly well-formed images with random content under the current
   // registers; the rest carry one flaw each or break the stream.
   task automatic random_image();
      int unsigned len;
      int          kind;
      logic [31:0] hver;
      logic [31:0] hsize;
      int          bad_at;
      bit          crc_good;
      int          pay_n;
      int          cut_n;
      len      = payload_len();
      kind     = $urandom_range(0, 99);
      hver     = cfg_version;
      hsize    = len;
      bad_at   = SIG_INTACT;
      crc_good = 1'b1;
      pay_n    = len;
      cut_n    = 0;
      if (kind < 60) begin
         // well-formed
      end else if (kind < 67) begin
         bad_at = $urandom_range(0, 7);
      end else if (kind < 73) begin
         hver = hver ^ (32'd1 << $urandom_range(0, 31));
      end else if (kind < 79) begin
         hsize = hsize ^ (32'd1 << $urandom_range(0, 31));
      end else if (kind < 85) begin
         crc_good = 1'b0;
      end else if (kind < 92) begin
         cut_n = $urandom_range(1, HEADER_BYTES_DEF + len - 1);
      end else begin
         // Bytes past the end of the image are dropped.
         pay_n = len + $urandom_range(1, 6);
      end
      tx_choppy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) == 0) send_strays($urandom_range(1, 4));
      run_image(hver, hsize, $urandom, bad_at, crc_good, pay_n, cut_n, 0, 32'd0);
   endtask

   initial begin
      logic [31:0] ver;
      logic [31:0] size;
      int          mark;
      int          rand_start;

      reset              = 1'b1;
      req_push           = 1'b0;
      req_data_byte      = '0;
      req_start_of_image = 1'b0;
      rsp_pop            = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_VERSION;
      csr_wdata          = '0;
      cfg_version        = CSR_VERSION_RST;
      cfg_size           = CSR_PAYLOAD_SIZE_RST;
      trk_idle           = 1'b1;
      trk_pos            = 0;
      trk_crc            = '1;
      trk_magic_ok       = 1'b1;
      trk_version        = '0;
      trk_size           = '0;
      trk_count          = '0;
      trk_stored_crc     = '0;
      typed_on           = 1'b0;
      typed_reason       = REASON_OK;
      calm               = 1'b0;
      tx_choppy          = 1'b1;
      rx_choppy          = 1'b1;
      stall_left         = 0;
      cycles             = 0;
      mismatches         = 0;
      verdicts_checked   = 0;
      images_sent        = 0;
      image_bytes        = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed images. Each one starts from a quiet block so that its
      // typed reason code, where given, applies to its own verdict only.
      for (int r = 0; r < PLAN_ROWS; r++) begin
         drain_results();
         typed_on     = PLAN[r].typed;
         typed_reason = PLAN[r].reason;
         if (PLAN[r].set_cfg) begin
            write_reg(CSR_VERSION, PLAN[r].cfg_version);
            write_reg(CSR_PAYLOAD_SIZE, PLAN[r].cfg_size);
         end
         tx_choppy = r[0];
         send_strays(int'(PLAN[r].strays));
         run_image(PLAN[r].hdr_version, PLAN[r].hdr_size, PLAN[r].hdr_count,
                   int'(PLAN[r].bad_magic), PLAN[r].crc_good, int'(PLAN[r].payload),
                   int'(PLAN[r].cut), int'(PLAN[r].resize_at), PLAN[r].resize_to);
      end
      drain_results();
      typed_on = 1'b0;

      // Random images in six register settings, small payloads throughout.
      // The last setting runs with no idling on either side.
      rand_start = image_bytes;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               ver  = 32'd0;
               size = 32'd1;
            end
            1: begin
               ver  = 32'hFFFF_FFFF;
               size = 32'd0;
            end
            2: begin
               ver  = $urandom;
               size = 32'd16;
            end
            3: begin
               // Bits above the register width must be dropped.
               ver  = $urandom;
               size = ($urandom & 32'hFFFF_8000) | $urandom_range(2, 40);
            end
            4: begin
               ver  = $urandom;
               size = 32'd3;
            end
            default: begin
               ver  = $urandom;
               size = $urandom_range(1, 24);
            end
         endcase
         write_reg(CSR_VERSION, ver);
         write_reg(CSR_PAYLOAD_SIZE, size);
         if (ph == 5) calm = 1'b1;
         mark = image_bytes;
         while (image_bytes - mark < RANDOM_BYTES / 6 ||
                (ph == 5 && image_bytes - rand_start < RANDOM_BYTES))
            random_image();
      end

      drain_results();
      $display("covered %0d images in %0d bytes, %0d verdicts compared, short payloads",
               images_sent, image_bytes, verdicts_checked);
      $display("every reason code, strays, abandoned, resized, clamped and overlong images");
      if (mismatches == 0) begin
         $display("save_image_header_crc_checker_unit_tb: done, clean");
      end else begin
         $display("save_image_header_crc_checker_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/shcc_pkg.sv
hw/rtl/shcc_fifo.sv
hw/rtl/shcc_front.sv
hw/rtl/shcc_back.sv
hw/rtl/save_image_header_crc_checker_unit.sv
bench/save_image_header_crc_checker_unit_tb.sv
